[hdl/source_text_tokenizer_top_macros.svh]
// ----------------------------------------------------------------------------
// source_text_tokenizer_top_macros.svh
// assertion helpers shared by the tokenizer modules
// ----------------------------------------------------------------------------
`ifndef SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_TOP_MACROS_SVH

// property that holds at every clock edge out of reset
`define STT_CHECK(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

// property that must hold in the cycle after a condition
`define STT_CHECK_NEXT(label, cond, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (cond) |=> (expr)) else $error(msg);

`endif

[hdl/stt_pkg.sv]
// ----------------------------------------------------------------------------
// stt_pkg
// token kinds, character codes, keyword tables and shared types
// ----------------------------------------------------------------------------
package stt_pkg;

    typedef logic [5:0] t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [31:0] start;
        logic [31:0] length;
        logic        last;
    } t_token;

    // results produced by one step of the lexer
    typedef struct packed {
        logic [1:0] count;
        t_token     tok0;
        t_token     tok1;
    } t_push;

    localparam t_kind K_EOF      = 6'd0;
    localparam t_kind K_LPAREN   = 6'd1;
    localparam t_kind K_RPAREN   = 6'd2;
    localparam t_kind K_PLUS     = 6'd3;
    localparam t_kind K_MINUS    = 6'd4;
    localparam t_kind K_ARROW    = 6'd5;
    localparam t_kind K_STAR     = 6'd6;
    localparam t_kind K_LT       = 6'd7;
    localparam t_kind K_LE       = 6'd8;
    localparam t_kind K_GT       = 6'd9;
    localparam t_kind K_GE       = 6'd10;
    localparam t_kind K_EQ       = 6'd11;
    localparam t_kind K_EQEQ     = 6'd12;
    localparam t_kind K_DARROW   = 6'd13;
    localparam t_kind K_COLON    = 6'd14;
    localparam t_kind K_DCOLON   = 6'd15;
    localparam t_kind K_BAR      = 6'd16;
    localparam t_kind K_BSLASH   = 6'd17;
    localparam t_kind K_SEMI     = 6'd18;
    localparam t_kind K_LBRACE   = 6'd19;
    localparam t_kind K_RBRACE   = 6'd20;
    localparam t_kind K_LBRACK   = 6'd21;
    localparam t_kind K_RBRACK   = 6'd22;
    localparam t_kind K_COMMA    = 6'd23;
    localparam t_kind K_AT       = 6'd24;
    localparam t_kind K_SLASH    = 6'd25;
    localparam t_kind K_SLASHEQ  = 6'd26;
    localparam t_kind K_LINECMT  = 6'd27;
    localparam t_kind K_BLKCMT   = 6'd28;
    localparam t_kind K_STRING   = 6'd29;
    localparam t_kind K_CHAR     = 6'd30;
    localparam t_kind K_INT      = 6'd31;
    localparam t_kind K_DEC      = 6'd32;
    localparam t_kind K_IDENT    = 6'd33;
    localparam t_kind K_KW_IF    = 6'd34;
    localparam t_kind K_KW_CLASS = 6'd35;
    localparam t_kind K_KW_DATA  = 6'd36;
    localparam t_kind K_KW_INST  = 6'd37;
    localparam t_kind K_KW_LET   = 6'd38;
    localparam t_kind K_KW_IN    = 6'd39;
    localparam t_kind K_KW_WHERE = 6'd40;
    localparam t_kind K_KW_BOOL  = 6'd41;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_D0     = 8'h30;
    localparam logic [7:0] CH_D9     = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_AT     = 8'h40;
    localparam logic [7:0] CH_UA     = 8'h41;
    localparam logic [7:0] CH_UZ     = 8'h5A;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] CH_LA     = 8'h61;
    localparam logic [7:0] CH_LZ     = 8'h7A;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_BAR    = 8'h7C;
    localparam logic [7:0] CH_RBRACE = 8'h7D;

    localparam int NUM_KW = 9;
    localparam logic [NUM_KW-1:0] KW_ALL = '1;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_D0 && c <= CH_D9;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ);
    endfunction

    function automatic logic [3:0] kw_len(input logic [3:0] k);
        case (k)
            4'd0:    return 4'd2;
            4'd1:    return 4'd5;
            4'd2:    return 4'd4;
            4'd3:    return 4'd8;
            4'd4:    return 4'd3;
            4'd5:    return 4'd2;
            4'd6:    return 4'd5;
            4'd7:    return 4'd4;
            4'd8:    return 4'd5;
            default: return 4'd0;
        endcase
    endfunction

    // keyword text right aligned, first character in the highest used byte
    function automatic logic [63:0] kw_word(input logic [3:0] k);
        case (k)
            4'd0:    return 64'("if");
            4'd1:    return 64'("class");
            4'd2:    return 64'("data");
            4'd3:    return 64'("instance");
            4'd4:    return 64'("let");
            4'd5:    return 64'("in");
            4'd6:    return 64'("where");
            4'd7:    return 64'("True");
            4'd8:    return 64'("False");
            default: return 64'd0;
        endcase
    endfunction

    function automatic t_kind kw_kind(input logic [3:0] k);
        case (k)
            4'd0:    return K_KW_IF;
            4'd1:    return K_KW_CLASS;
            4'd2:    return K_KW_DATA;
            4'd3:    return K_KW_INST;
            4'd4:    return K_KW_LET;
            4'd5:    return K_KW_IN;
            4'd6:    return K_KW_WHERE;
            4'd7:    return K_KW_BOOL;
            4'd8:    return K_KW_BOOL;
            default: return K_IDENT;
        endcase
    endfunction

    // drop every keyword whose character at idx is not c
    function automatic logic [NUM_KW-1:0] kw_step(input logic [NUM_KW-1:0] mask,
                                                  input logic [3:0] idx,
                                                  input logic [7:0] c);
        logic [NUM_KW-1:0] res;
        logic [63:0]       w;
        logic [3:0]        sh;
        res = mask;
        for (int k = 0; k < NUM_KW; k++) begin
            sh = kw_len(4'(k)) - 4'd1 - idx;
            w  = kw_word(4'(k)) >> {sh, 3'b000};
            if (idx >= kw_len(4'(k)) || w[7:0] != c) begin
                res[k] = 1'b0;
            end
        end
        return res;
    endfunction

    function automatic t_kind ident_kind(input logic [NUM_KW-1:0] mask,
                                         input logic [3:0] len);
        t_kind res;
        res = K_IDENT;
        // walk down so the lowest matching keyword wins
        for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (mask[k] && kw_len(4'(k)) == len) begin
                res = kw_kind(4'(k));
            end
        end
        return res;
    endfunction

endpackage

[hdl/stt_lexer.sv]
// ----------------------------------------------------------------------------
// stt_lexer
// scanner state and one-character step: mode, position, keyword mask
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_top_macros.svh"

module stt_lexer #(
    parameter int POS_BITS = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_advance,
    input  logic [7:0]     i_ch,
    input  logic           i_is_end,
    output stt_pkg::t_push o_push
);
    import stt_pkg::*;

    localparam logic [4:0] M_IDLE    = 5'd0;
    localparam logic [4:0] M_SLASH   = 5'd1;
    localparam logic [4:0] M_LINE    = 5'd2;
    localparam logic [4:0] M_BLOCK   = 5'd3;
    localparam logic [4:0] M_BSTAR   = 5'd4;
    localparam logic [4:0] M_STRING  = 5'd5;
    localparam logic [4:0] M_CH_OPEN = 5'd6;
    localparam logic [4:0] M_CH_ESC  = 5'd7;
    localparam logic [4:0] M_CH_BODY = 5'd8;
    localparam logic [4:0] M_MINUS   = 5'd9;
    localparam logic [4:0] M_LT      = 5'd10;
    localparam logic [4:0] M_GT      = 5'd11;
    localparam logic [4:0] M_EQ      = 5'd12;
    localparam logic [4:0] M_COLON   = 5'd13;
    localparam logic [4:0] M_INT     = 5'd14;
    localparam logic [4:0] M_FRAC    = 5'd15;
    localparam logic [4:0] M_IDENT   = 5'd16;

    logic [4:0]          r_mode,  n_mode;
    logic [POS_BITS-1:0] r_pos,   n_pos;
    logic [POS_BITS-1:0] r_start, n_start;
    logic [NUM_KW-1:0]   r_kw,    n_kw;
    logic [3:0]          r_idlen, n_idlen;

    logic [POS_BITS-1:0] cur, nx, len_cur, len_nx;

    // what a token starting with i_ch does
    logic [4:0]        st_mode;
    logic              st_single;
    t_kind             st_kind;
    logic [NUM_KW-1:0] st_kw;
    logic [3:0]        st_idlen;

    logic  fin, brk, restart;
    t_kind fin_kind;
    t_push push;

    function automatic logic [31:0] sat32(input logic [POS_BITS-1:0] v);
        logic [63:0] w;
        w = 64'(v);
        return (w > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : w[31:0];
    endfunction

    function automatic t_kind pend_kind(input logic [4:0] m,
                                        input logic [NUM_KW-1:0] kw,
                                        input logic [3:0] len);
        case (m)
            M_SLASH:   return K_SLASH;
            M_LINE:    return K_LINECMT;
            M_BLOCK:   return K_BLKCMT;
            M_BSTAR:   return K_BLKCMT;
            M_STRING:  return K_STRING;
            M_CH_OPEN: return K_CHAR;
            M_CH_ESC:  return K_CHAR;
            M_CH_BODY: return K_CHAR;
            M_MINUS:   return K_MINUS;
            M_LT:      return K_LT;
            M_GT:      return K_GT;
            M_EQ:      return K_EQ;
            M_COLON:   return K_COLON;
            M_INT:     return K_INT;
            M_FRAC:    return K_DEC;
            default:   return ident_kind(kw, len);
        endcase
    endfunction

    assign cur     = r_pos;
    assign nx      = r_pos + POS_BITS'(1);
    assign len_cur = cur - r_start;
    assign len_nx  = nx - r_start;

    always_comb begin
        st_mode   = M_IDLE;
        st_single = 1'b0;
        st_kind   = K_EOF;
        st_kw     = r_kw;
        st_idlen  = r_idlen;
        case (i_ch)
            CH_SLASH:  st_mode = M_SLASH;
            CH_DQUOTE: st_mode = M_STRING;
            CH_APOS:   st_mode = M_CH_OPEN;
            CH_MINUS:  st_mode = M_MINUS;
            CH_LT:     st_mode = M_LT;
            CH_GT:     st_mode = M_GT;
            CH_EQ:     st_mode = M_EQ;
            CH_COLON:  st_mode = M_COLON;
            CH_LPAREN: begin st_single = 1'b1; st_kind = K_LPAREN; end
            CH_RPAREN: begin st_single = 1'b1; st_kind = K_RPAREN; end
            CH_PLUS:   begin st_single = 1'b1; st_kind = K_PLUS;   end
            CH_STAR:   begin st_single = 1'b1; st_kind = K_STAR;   end
            CH_BAR:    begin st_single = 1'b1; st_kind = K_BAR;    end
            CH_BSLASH: begin st_single = 1'b1; st_kind = K_BSLASH; end
            CH_SEMI:   begin st_single = 1'b1; st_kind = K_SEMI;   end
            CH_LBRACE: begin st_single = 1'b1; st_kind = K_LBRACE; end
            CH_RBRACE: begin st_single = 1'b1; st_kind = K_RBRACE; end
            CH_LBRACK: begin st_single = 1'b1; st_kind = K_LBRACK; end
            CH_RBRACK: begin st_single = 1'b1; st_kind = K_RBRACK; end
            CH_COMMA:  begin st_single = 1'b1; st_kind = K_COMMA;  end
            CH_AT:     begin st_single = 1'b1; st_kind = K_AT;     end
            default: begin
                if (is_digit(i_ch)) begin
                    st_mode = M_INT;
                end else if (is_alpha(i_ch) || i_ch == CH_UNDER) begin
                    st_mode  = M_IDENT;
                    st_kw    = kw_step(KW_ALL, 4'd0, i_ch);
                    st_idlen = 4'd1;
                end
            end
        endcase
    end

    always_comb begin
        n_mode   = r_mode;
        n_pos    = nx;
        n_start  = r_start;
        n_kw     = r_kw;
        n_idlen  = r_idlen;
        fin      = 1'b0;
        fin_kind = K_EOF;
        brk      = 1'b0;
        restart  = 1'b0;
        push     = '0;

        if (i_is_end) begin
            // flush the pending token, then end-of-file, then back to reset state
            if (r_mode != M_IDLE) begin
                push.count = 2'd2;
                push.tok0  = '{kind: pend_kind(r_mode, r_kw, r_idlen),
                               start: 32'(r_start), length: sat32(len_cur),
                               last: 1'b0};
                push.tok1  = '{kind: K_EOF, start: 32'(cur), length: 32'd0,
                               last: 1'b1};
            end else begin
                push.count = 2'd1;
                push.tok0  = '{kind: K_EOF, start: 32'(cur), length: 32'd0,
                               last: 1'b1};
            end
            n_mode  = M_IDLE;
            n_pos   = '0;
            n_start = '0;
            n_kw    = KW_ALL;
            n_idlen = 4'd0;
        end else begin
            case (r_mode)
                M_SLASH: begin
                    if (i_ch == CH_SLASH) n_mode = M_LINE;
                    else if (i_ch == CH_STAR) n_mode = M_BLOCK;
                    else if (i_ch == CH_EQ) begin fin = 1'b1; fin_kind = K_SLASHEQ; end
                    else brk = 1'b1;
                end
                M_LINE: begin
                    if (i_ch == CH_LF) brk = 1'b1;
                end
                M_BLOCK: begin
                    if (i_ch == CH_STAR) n_mode = M_BSTAR;
                end
                M_BSTAR: begin
                    if (i_ch == CH_SLASH) begin fin = 1'b1; fin_kind = K_BLKCMT; end
                    else if (i_ch != CH_STAR) n_mode = M_BLOCK;
                end
                M_STRING: begin
                    if (i_ch == CH_DQUOTE) begin fin = 1'b1; fin_kind = K_STRING; end
                end
                M_CH_OPEN: begin
                    n_mode = (i_ch == CH_BSLASH) ? M_CH_ESC : M_CH_BODY;
                end
                M_CH_ESC: begin
                    n_mode = M_CH_BODY;
                end
                M_CH_BODY: begin
                    if (i_ch == CH_APOS) begin fin = 1'b1; fin_kind = K_CHAR; end
                    else brk = 1'b1;
                end
                M_MINUS: begin
                    if (i_ch == CH_GT) begin fin = 1'b1; fin_kind = K_ARROW; end
                    else brk = 1'b1;
                end
                M_LT: begin
                    if (i_ch == CH_EQ) begin fin = 1'b1; fin_kind = K_LE; end
                    else brk = 1'b1;
                end
                M_GT: begin
                    if (i_ch == CH_EQ) begin fin = 1'b1; fin_kind = K_GE; end
                    else brk = 1'b1;
                end
                M_EQ: begin
                    if (i_ch == CH_EQ) begin fin = 1'b1; fin_kind = K_EQEQ; end
                    else if (i_ch == CH_GT) begin fin = 1'b1; fin_kind = K_DARROW; end
                    else brk = 1'b1;
                end
                M_COLON: begin
                    if (i_ch == CH_COLON) begin fin = 1'b1; fin_kind = K_DCOLON; end
                    else brk = 1'b1;
                end
                M_INT: begin
                    if (i_ch == CH_DOT) n_mode = M_FRAC;
                    else if (!is_digit(i_ch)) brk = 1'b1;
                end
                M_FRAC: begin
                    if (!is_digit(i_ch)) brk = 1'b1;
                end
                M_IDENT: begin
                    if (is_alpha(i_ch) || is_digit(i_ch) || i_ch == CH_UNDER) begin
                        n_kw    = kw_step(r_kw, r_idlen, i_ch);
                        n_idlen = (r_idlen == 4'hF) ? r_idlen : r_idlen + 4'd1;
                    end else begin
                        brk = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase

            if (fin) begin
                push.count = 2'd1;
                push.tok0  = '{kind: fin_kind, start: 32'(r_start),
                               length: sat32(len_nx), last: 1'b1};
                n_mode     = M_IDLE;
            end

            // the byte that ended a token is scanned as the start of the next
            if (brk || restart) begin
                n_mode  = st_mode;
                n_kw    = st_kw;
                n_idlen = st_idlen;
                if (!is_space(i_ch)) begin
                    n_start = cur;
                end
            end

            if (brk) begin
                push.count = st_single ? 2'd2 : 2'd1;
                push.tok0  = '{kind: pend_kind(r_mode, r_kw, r_idlen),
                               start: 32'(r_start), length: sat32(len_cur),
                               last: !st_single};
                push.tok1  = '{kind: st_kind, start: 32'(cur), length: 32'd1,
                               last: 1'b1};
            end else if (restart && st_single) begin
                push.count = 2'd1;
                push.tok0  = '{kind: st_kind, start: 32'(cur), length: 32'd1,
                               last: 1'b1};
            end
        end
    end

    assign o_push = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_pos   <= '0;
            r_start <= '0;
            r_kw    <= KW_ALL;
            r_idlen <= 4'd0;
        end else if (i_advance) begin
            r_mode  <= n_mode;
            r_pos   <= n_pos;
            r_start <= n_start;
            r_kw    <= n_kw;
            r_idlen <= n_idlen;
        end
    end

    `STT_CHECK_NEXT(a_end_resets, i_advance && i_is_end,
        r_mode == M_IDLE && r_pos == '0 && r_start == '0, "end marker left state")
    `STT_CHECK(a_fresh_mask, r_idlen != 4'd0 || r_kw == KW_ALL,
        "keyword mask narrowed with no identifier characters")

endmodule

[hdl/stt_out_stage.sv]
// ----------------------------------------------------------------------------
// stt_out_stage
// result register holding up to two tokens from one step, shown one at a time
// ----------------------------------------------------------------------------
`include "source_text_tokenizer_top_macros.svh"

module stt_out_stage (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  stt_pkg::t_push  i_push,
    input  logic            i_ready,
    output logic            o_valid,
    output stt_pkg::t_token o_tok,
    output logic            o_free
);
    import stt_pkg::*;

    logic   r_valid;
    logic   r_two;
    logic   r_sel;
    t_token r_tok0;
    t_token r_tok1;
    logic   cur_last;
    logic   pop;

    assign o_valid  = r_valid;
    assign o_tok    = r_sel ? r_tok1 : r_tok0;
    assign cur_last = r_sel || !r_two;
    assign pop      = r_valid && i_ready;
    // register can take a new step when empty or its last token leaves now
    assign o_free   = !r_valid || (i_ready && cur_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_two   <= 1'b0;
            r_sel   <= 1'b0;
        end else if (i_load) begin
            r_valid <= (i_push.count != 2'd0);
            r_two   <= (i_push.count == 2'd2);
            r_sel   <= 1'b0;
        end else if (pop) begin
            if (cur_last) begin
                r_valid <= 1'b0;
                r_sel   <= 1'b0;
            end else begin
                r_sel <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_tok0 <= i_push.tok0;
            r_tok1 <= i_push.tok1;
        end
    end

    `STT_CHECK(a_sel_pair, !r_sel || (r_two && r_valid),
        "second slot shown without a pair")
    `STT_CHECK_NEXT(a_second_follows, pop && !cur_last && !i_load,
        r_valid && r_sel, "second token of pair lost")

endmodule

[hdl/source_text_tokenizer_top.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_top
// streaming tokenizer: one source byte in, finished tokens out
// ----------------------------------------------------------------------------
// input stream s_axis: tdata[7:0] is the source byte, tuser[0] marks the end
// of the source (byte ignored). output stream m_axis: tdata[31:0] token start,
// tdata[63:32] token length, tuser[5:0] token kind, tlast marks the final
// token caused by one input transaction.
// each byte passes an input register, the combinational scanner logic and a
// result register before a completed token is valid on m_axis. one byte is
// taken per cycle while each byte yields at most one token and m_axis is
// ready; a byte that yields two tokens (a pending token plus a one-character
// operator, or a flush plus end-of-file) holds the input while the result
// register drains its second token.
// the end marker flushes any pending token, emits end-of-file and returns the
// position counter and scanner to their reset state.
// reset clears the scanner and both registers. when m_axis stalls the result
// register holds, the input register still takes one more byte, then
// s_axis_tready drops until the result is taken.
// ----------------------------------------------------------------------------
module source_text_tokenizer_top #(
    parameter int POS_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,  // [7:0] ch
    input  logic [0:0]  s_axis_tuser,  // [0] is_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,  // [31:0] token_start, [63:32] token_length
    output logic [5:0]  m_axis_tuser,  // [5:0] token_kind
    output logic        m_axis_tlast   // last_of_run
);
    import stt_pkg::*;

    logic       r_in_valid;
    logic [7:0] r_in_ch;
    logic       r_in_end;
    logic       advance;
    logic       out_free;
    t_push      push;
    t_token     tok;

    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_ch  <= s_axis_tdata;
            r_in_end <= s_axis_tuser[0];
        end
    end

    stt_lexer #(
        .POS_BITS (POS_BITS)
    ) u_lexer (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_ch      (r_in_ch),
        .i_is_end  (r_in_end),
        .o_push    (push)
    );

    stt_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (advance),
        .i_push  (push),
        .i_ready (m_axis_tready),
        .o_valid (m_axis_tvalid),
        .o_tok   (tok),
        .o_free  (out_free)
    );

    assign m_axis_tdata = {tok.length, tok.start};
    assign m_axis_tuser = tok.kind;
    assign m_axis_tlast = tok.last;

endmodule

[test/source_text_tokenizer_checker.sv]
// ----------------------------------------------------------------------------
// source_text_tokenizer_checker
// watches both streams of the tokenizer, predicts every token from the
// accepted source bytes and compares each output transaction field by field
// ----------------------------------------------------------------------------
module source_text_tokenizer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    input  logic        i_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,  // [7:0] ch
    input  logic [0:0]  i_s_axis_tuser,  // [0] is_end
    input  logic        i_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    input  logic [63:0] i_m_axis_tdata,  // [31:0] token_start, [63:32] token_length
    input  logic [5:0]  i_m_axis_tuser,  // [5:0] token_kind
    input  logic        i_m_axis_tlast,
    output int          o_fail_count,
    output int          o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    typedef enum logic [4:0] {
        SC_IDLE, SC_SLASH, SC_LINE, SC_BLOCK, SC_BSTAR, SC_STRING,
        SC_CH_OPEN, SC_CH_ESC, SC_CH_BODY, SC_MINUS, SC_LT, SC_GT,
        SC_EQ, SC_COLON, SC_INT, SC_FRAC, SC_IDENT
    } t_scan;

    t_scan             scan;
    logic [31:0]       pos;
    logic [31:0]       tok_start;
    logic [NUM_KW-1:0] kw_cand;
    logic [3:0]        word_len;

    t_token tok_buf [2];
    int     tok_cnt;
    t_token token_q [$];
    int     mismatches = 0;

    function automatic logic ws_char(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic digit_char(input logic [7:0] c);
        return (c >= CH_D0) && (c <= CH_D9);
    endfunction

    function automatic logic word_char(input logic [7:0] c);
        return (c >= CH_LA && c <= CH_LZ) || (c >= CH_UA && c <= CH_UZ) ||
               (c == CH_UNDER);
    endfunction

    function automatic string kw_name(input int k);
        case (k)
            0:       return "if";
            1:       return "class";
            2:       return "data";
            3:       return "instance";
            4:       return "let";
            5:       return "in";
            6:       return "where";
            7:       return "True";
            default: return "False";
        endcase
    endfunction

    function automatic t_kind kw_token(input int k);
        case (k)
            0:       return K_KW_IF;
            1:       return K_KW_CLASS;
            2:       return K_KW_DATA;
            3:       return K_KW_INST;
            4:       return K_KW_LET;
            5:       return K_KW_IN;
            6:       return K_KW_WHERE;
            default: return K_KW_BOOL;
        endcase
    endfunction

    task automatic reset_lexer();
        scan      = SC_IDLE;
        pos       = '0;
        tok_start = '0;
        kw_cand   = '1;
        word_len  = '0;
    endtask

    task automatic kw_advance(input logic [7:0] c);
        string w;
        for (int k = 0; k < NUM_KW; k++) begin
            w = kw_name(k);
            if (word_len >= w.len() || w[word_len] != c) begin
                kw_cand[k] = 1'b0;
            end
        end
        if (word_len < 4'd15) begin
            word_len = word_len + 4'd1;
        end
    endtask

    // first keyword still matching at the full length wins
    function automatic t_kind word_kind();
        t_kind res;
        string w;
        logic  found;
        res   = K_IDENT;
        found = 1'b0;
        for (int k = 0; k < NUM_KW; k++) begin
            w = kw_name(k);
            if (!found && kw_cand[k] && word_len == w.len()) begin
                res   = kw_token(k);
                found = 1'b1;
            end
        end
        return res;
    endfunction

    function automatic t_kind held_kind(input t_scan m);
        case (m)
            SC_SLASH:                          return K_SLASH;
            SC_LINE:                           return K_LINECMT;
            SC_BLOCK, SC_BSTAR:                return K_BLKCMT;
            SC_STRING:                         return K_STRING;
            SC_CH_OPEN, SC_CH_ESC, SC_CH_BODY: return K_CHAR;
            SC_MINUS:                          return K_MINUS;
            SC_LT:                             return K_LT;
            SC_GT:                             return K_GT;
            SC_EQ:                             return K_EQ;
            SC_COLON:                          return K_COLON;
            SC_INT:                            return K_INT;
            SC_FRAC:                           return K_DEC;
            default:                           return word_kind();
        endcase
    endfunction

    task automatic emit_tok(input t_kind k, input logic [31:0] stop);
        if (tok_cnt < 2) begin
            tok_buf[tok_cnt].kind   = k;
            tok_buf[tok_cnt].start  = tok_start;
            tok_buf[tok_cnt].length = stop - tok_start;
            tok_buf[tok_cnt].last   = 1'b0;
            tok_cnt++;
        end
    endtask

    task automatic begin_token(input logic [7:0] c, input logic [31:0] cur);
        t_kind k;
        scan = SC_IDLE;
        if (!ws_char(c)) begin
            tok_start = cur;
            k = K_EOF;  // no single-character token
            case (c)
                CH_SLASH:  scan = SC_SLASH;
                CH_DQUOTE: scan = SC_STRING;
                CH_APOS:   scan = SC_CH_OPEN;
                CH_MINUS:  scan = SC_MINUS;
                CH_LT:     scan = SC_LT;
                CH_GT:     scan = SC_GT;
                CH_EQ:     scan = SC_EQ;
                CH_COLON:  scan = SC_COLON;
                CH_LPAREN: k = K_LPAREN;
                CH_RPAREN: k = K_RPAREN;
                CH_PLUS:   k = K_PLUS;
                CH_STAR:   k = K_STAR;
                CH_BAR:    k = K_BAR;
                CH_BSLASH: k = K_BSLASH;
                CH_SEMI:   k = K_SEMI;
                CH_LBRACE: k = K_LBRACE;
                CH_RBRACE: k = K_RBRACE;
                CH_LBRACK: k = K_LBRACK;
                CH_RBRACK: k = K_RBRACK;
                CH_COMMA:  k = K_COMMA;
                CH_AT:     k = K_AT;
                default:   ;
            endcase
            if (k != K_EOF) begin
                emit_tok(k, cur + 32'd1);
            end else if (scan == SC_IDLE) begin
                if (digit_char(c)) begin
                    scan = SC_INT;
                end else if (word_char(c)) begin
                    scan     = SC_IDENT;
                    kw_cand  = '1;
                    word_len = '0;
                    kw_advance(c);
                end
            end
        end
    endtask

    task automatic lex_step(input logic [7:0] c, input logic is_end);
        logic [31:0] cur;
        logic [31:0] nx;
        logic        done;
        t_scan       m;
        tok_cnt = 0;
        cur     = pos;
        nx      = pos + 32'd1;
        done    = 1'b1;
        m       = scan;
        if (is_end) begin
            if (m != SC_IDLE) begin
                emit_tok(held_kind(m), cur);
            end
            tok_start = cur;
            emit_tok(K_EOF, cur);
            reset_lexer();
        end else begin
            case (m)
                SC_SLASH: begin
                    if (c == CH_SLASH) scan = SC_LINE;
                    else if (c == CH_STAR) scan = SC_BLOCK;
                    else if (c == CH_EQ) begin
                        emit_tok(K_SLASHEQ, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_LINE: begin
                    if (c == CH_LF) done = 1'b0;
                end
                SC_BLOCK: begin
                    if (c == CH_STAR) scan = SC_BSTAR;
                end
                SC_BSTAR: begin
                    if (c == CH_SLASH) begin
                        emit_tok(K_BLKCMT, nx);
                        scan = SC_IDLE;
                    end else if (c != CH_STAR) scan = SC_BLOCK;
                end
                SC_STRING: begin
                    if (c == CH_DQUOTE) begin
                        emit_tok(K_STRING, nx);
                        scan = SC_IDLE;
                    end
                end
                SC_CH_OPEN: scan = (c == CH_BSLASH) ? SC_CH_ESC : SC_CH_BODY;
                SC_CH_ESC:  scan = SC_CH_BODY;
                SC_CH_BODY: begin
                    if (c == CH_APOS) begin
                        emit_tok(K_CHAR, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_MINUS: begin
                    if (c == CH_GT) begin
                        emit_tok(K_ARROW, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_LT: begin
                    if (c == CH_EQ) begin
                        emit_tok(K_LE, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_GT: begin
                    if (c == CH_EQ) begin
                        emit_tok(K_GE, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_EQ: begin
                    if (c == CH_EQ) begin
                        emit_tok(K_EQEQ, nx);
                        scan = SC_IDLE;
                    end else if (c == CH_GT) begin
                        emit_tok(K_DARROW, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_COLON: begin
                    if (c == CH_COLON) begin
                        emit_tok(K_DCOLON, nx);
                        scan = SC_IDLE;
                    end else done = 1'b0;
                end
                SC_INT: begin
                    if (c == CH_DOT) scan = SC_FRAC;
                    else if (!digit_char(c)) done = 1'b0;
                end
                SC_FRAC: begin
                    if (!digit_char(c)) done = 1'b0;
                end
                SC_IDENT: begin
                    if (word_char(c) || digit_char(c)) kw_advance(c);
                    else done = 1'b0;
                end
                default: begin_token(c, cur);
            endcase
            // the byte that ended a pending token starts the next one
            if (!done) begin
                emit_tok(held_kind(m), cur);
                begin_token(c, cur);
            end
            pos = nx;
        end
        if (tok_cnt > 0) begin
            tok_buf[tok_cnt-1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_token want;
        if (!i_rst_n) begin
            reset_lexer();
        end else begin
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                lex_step(i_s_axis_tdata, i_s_axis_tuser[0]);
                for (int i = 0; i < tok_cnt; i++) begin
                    token_q.push_back(tok_buf[i]);
                end
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (token_q.size() == 0) begin
                    mismatches++;
                    $error("token with no expectation: kind %0d start %0d length %0d",
                           i_m_axis_tuser, i_m_axis_tdata[31:0], i_m_axis_tdata[63:32]);
                end else begin
                    want = token_q.pop_front();
                    if (i_m_axis_tuser !== want.kind) begin
                        mismatches++;
                        $error("token_kind: expected %0d, actual %0d",
                               want.kind, i_m_axis_tuser);
                    end
                    if (i_m_axis_tdata[31:0] !== want.start) begin
                        mismatches++;
                        $error("token_start: expected %0d, actual %0d",
                               want.start, i_m_axis_tdata[31:0]);
                    end
                    if (i_m_axis_tdata[63:32] !== want.length) begin
                        mismatches++;
                        $error("token_length: expected %0d, actual %0d",
                               want.length, i_m_axis_tdata[63:32]);
                    end
                    if (i_m_axis_tlast !== want.last) begin
                        mismatches++;
                        $error("last_of_run: expected %0d, actual %0d",
                               want.last, i_m_axis_tlast);
                    end
                end
            end
        end
        o_fail_count  <= mismatches;
        o_outstanding <= token_q.size();
    end

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// drives source byte streams into the tokenizer: a few directed corner cases,
// then random well-formed token sequences mixed with noise and end markers,
// under several sender idle and receiver stall patterns
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stt_pkg::*;

    localparam int ITEMS_PER_PHASE = 420;
    localparam int HOLD_CYCLES     = 300;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int TAIL_CYCLES     = 8;

    localparam logic [7:0] CH_VT = 8'h0B;
    localparam logic [7:0] CH_FF = 8'h0C;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;  // [7:0] ch
    logic [0:0]  s_axis_tuser  = '0;  // [0] is_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [31:0] token_start, [63:32] token_length
    logic [5:0]  m_axis_tuser;        // [5:0] token_kind
    logic        m_axis_tlast;

    int fail_count;
    int outstanding;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_req       = 0;
    int hold_ack       = 0;
    int hold_left      = 0;
    int quiet_cycles   = 0;

    logic [8:0] src_q [$];  // {is_end, ch}
    string      ident_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_";
    string      block_chars = "ab */\n";

    source_text_tokenizer_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    source_text_tokenizer_checker checker_i (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .i_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .i_s_axis_tuser  (s_axis_tuser),
        .i_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .i_m_axis_tdata  (m_axis_tdata),
        .i_m_axis_tuser  (m_axis_tuser),
        .i_m_axis_tlast  (m_axis_tlast),
        .o_fail_count    (fail_count),
        .o_outstanding   (outstanding)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge i_clk) begin
        if (hold_left > 0) begin
            m_axis_tready <= 1'b0;
            hold_left     <= hold_left - 1;
        end else if (hold_req != hold_ack) begin
            m_axis_tready <= 1'b0;
            hold_ack      <= hold_req;
            hold_left     <= HOLD_CYCLES;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic push_char(input logic [7:0] c);
        src_q.push_back({1'b0, c});
    endtask

    task automatic push_end();
        src_q.push_back({1'b1, 8'($urandom_range(255))});
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            push_char(s[i]);
        end
    endtask

    task automatic push_ws();
        case ($urandom_range(5))
            0:       push_char(CH_TAB);
            1:       push_char(CH_LF);
            2:       push_char(CH_VT);
            3:       push_char(CH_FF);
            4:       push_char(CH_CR);
            default: push_char(CH_SPACE);
        endcase
    endtask

    function automatic string pick_keyword();
        case ($urandom_range(8))
            0:       return "if";
            1:       return "class";
            2:       return "data";
            3:       return "instance";
            4:       return "let";
            5:       return "in";
            6:       return "where";
            7:       return "True";
            default: return "False";
        endcase
    endfunction

    function automatic string pick_operator();
        case ($urandom_range(25))
            0:       return "(";
            1:       return ")";
            2:       return "+";
            3:       return "-";
            4:       return "->";
            5:       return "*";
            6:       return "<";
            7:       return "<=";
            8:       return ">";
            9:       return ">=";
            10:      return "=";
            11:      return "==";
            12:      return "=>";
            13:      return ":";
            14:      return "::";
            15:      return "|";
            16:      return "\\";
            17:      return ";";
            18:      return "{";
            19:      return "}";
            20:      return "[";
            21:      return "]";
            22:      return ",";
            23:      return "@";
            24:      return "/";
            default: return "/=";
        endcase
    endfunction

    // one random token, mostly well formed, with an optional separator
    task automatic add_token();
        logic [7:0] b;
        int         n;
        case ($urandom_range(15))
            0, 1: begin
                push_text(pick_keyword());
                if ($urandom_range(3) == 0) begin
                    push_char(ident_chars[$urandom_range(ident_chars.len() - 1)]);
                end
            end
            2, 3: begin
                push_char(ident_chars[$urandom_range(52)]);
                n = $urandom_range(19);
                repeat (n) push_char(ident_chars[$urandom_range(ident_chars.len() - 1)]);
            end
            4: begin
                n = $urandom_range(1, 6);
                repeat (n) push_char(CH_D0 + 8'($urandom_range(9)));
            end
            5: begin
                n = $urandom_range(1, 4);
                repeat (n) push_char(CH_D0 + 8'($urandom_range(9)));
                push_char(CH_DOT);
                n = $urandom_range(4);
                repeat (n) push_char(CH_D0 + 8'($urandom_range(9)));
            end
            6: begin
                push_char(CH_DQUOTE);
                n = $urandom_range(8);
                repeat (n) begin
                    b = 8'($urandom_range(255));
                    push_char((b == CH_DQUOTE) ? CH_UA : b);
                end
                if ($urandom_range(9) != 0) push_char(CH_DQUOTE);
            end
            7: begin
                push_char(CH_APOS);
                if ($urandom_range(3) == 0) push_char(CH_BSLASH);
                push_char(8'($urandom_range(255)));
                if ($urandom_range(4) != 0) push_char(CH_APOS);
            end
            8: begin
                push_text("//");
                n = $urandom_range(10);
                repeat (n) begin
                    b = 8'($urandom_range(255));
                    push_char((b == CH_LF) ? CH_UA : b);
                end
                push_char(CH_LF);
            end
            9: begin
                push_text("/*");
                n = $urandom_range(6);
                repeat (n) push_char(block_chars[$urandom_range(block_chars.len() - 1)]);
                if ($urandom_range(1) == 0) push_char(CH_STAR);
                push_text("*/");
            end
            10, 11, 12: push_text(pick_operator());
            13: push_char(8'($urandom_range(255)));
            14: push_end();
            default: begin
                n = $urandom_range(1, 3);
                repeat (n) push_ws();
            end
        endcase
        if ($urandom_range(9) < 6) begin
            push_ws();
        end
    endtask

    task automatic send_item(input logic [8:0] item);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item[7:0];
        s_axis_tuser  <= item[8];
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // send everything queued, then pause until every token has arrived
    task automatic send_and_drain();
        while (src_q.size() > 0) begin
            send_item(src_q.pop_front());
        end
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // eof on an empty source, dropped bytes, high bytes inside a string,
        // block comment closed at the first star-slash, char literal without
        // its closing quote, decimal with no fraction, unterminated string
        push_end();
        push_char(8'h00);
        push_char(8'hFF);
        push_char(8'h80);
        push_char(CH_DQUOTE);
        push_char(8'h00);
        push_char(8'hFF);
        push_char(CH_DQUOTE);
        push_text("/*x**/");
        push_text("'ab");
        push_text("1. ");
        push_text("\"ab");
        push_end();
        send_and_drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 0;
                    hold_req       <= hold_req + 1;
                end
                1: begin
                    send_idle_pct  <= 82;
                    recv_stall_pct <= 0;
                end
                2: begin
                    send_idle_pct  <= 0;
                    recv_stall_pct <= 82;
                end
                default: begin
                    send_idle_pct  <= 11;
                    recv_stall_pct <= 11;
                end
            endcase
            while (src_q.size() < ITEMS_PER_PHASE) begin
                add_token();
            end
            push_end();
            send_and_drain();
        end

        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
